[rtl/core/ple_pkg.sv]
// Package for the positional list engine: request and status codes,
// cell command type and default sizes. No dependencies.
package ple_pkg;

    // Default number of list slots
    localparam int PLE_DEPTH = 16;
    // Reset value of the max_entries register
    localparam logic [4:0] PLE_MAX_RESET = 5'd16;

    // Configuration register indexes
    localparam int unsigned REG_MAX_ENTRIES = 0;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_LOCATE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BADPOS   = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    // Operation broadcast to every cell in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MATCH,
        CELL_SCAN
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [4:0]  pos;
        logic [31:0] value;
    } t_cell_cmd;

    typedef enum logic {
        ST_RUN,
        ST_SCAN
    } t_state;

endpackage

[rtl/core/ple_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing but plain logic types.
interface ple_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [4:0]  position;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink (input valid, input req_type, input position, input value,
                  output ready);
endinterface

interface ple_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] read_value;
    logic [4:0]  found_position;

    modport source (output valid, output status, output read_value,
                    output found_position, input ready);
    modport sink (input valid, input status, input read_value,
                  input found_position, output ready);
endinterface

[rtl/core/ple_cell.sv]
// One slot of the list: holds an entry and a match flag, shifts with its
// neighbours on insert, delete and scan. Depends on ple_pkg.
module ple_cell import ple_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_cmd   i_cmd,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    input  logic        i_right_match,
    output logic [31:0] o_value,
    output logic        o_match,
    output logic [31:0] o_sel_value
);

    // 1-based position of this slot
    localparam logic [31:0] KP1 = 32'(IDX + 1);

    logic [31:0] r_value, n_value;
    logic        r_match, n_match;
    logic [31:0] w_pos;
    logic        w_sel;

    assign w_pos = {27'd0, i_cmd.pos};
    assign w_sel = (KP1 == w_pos);

    // Pick next entry and match flag
    always_comb begin
        n_value = r_value;
        n_match = r_match;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (w_sel) begin
                    n_value = i_cmd.value;
                end else if (KP1 > w_pos) begin
                    n_value = i_left;
                end
            end
            CELL_DELETE: begin
                if (KP1 >= w_pos) begin
                    n_value = i_right;
                end
            end
            CELL_MATCH: n_match = (r_value == i_cmd.value);
            CELL_SCAN:  n_match = i_right_match;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_match <= 1'b0;
        end else begin
            r_value <= n_value;
            r_match <= n_match;
        end
    end

    assign o_value     = r_value;
    assign o_match     = r_match;
    assign o_sel_value = w_sel ? r_value : 32'd0;

endmodule

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: request decode, count,
// locate scan, output register and APB register. Depends on ple_pkg,
// ple_if and ple_cell.
//
// Usage:
//   Requests arrive on i_req (valid/ready); each gives one response on o_rsp.
//   Insert, delete and get answer without a scan: the response is registered
//   at the edge that takes the request, and a new request is taken in the same
//   cycle that the previous response is taken.
//   Locate captures a compare in every cell, then shifts the match flags
//   along the cell row one slot a cycle toward the head until the first hit
//   or the last entry in use; no request is taken meanwhile.
//   max_entries is to be written over APB only while the block is idle (not
//   enforced by the block); it reads back on prdata, and pready is always high.
//   Reset clears every slot, the entry count and the output register, and
//   sets max_entries to 16. While the receiver stalls, the response holds
//   and i_req.ready stays low, so nothing is lost.
module positional_list_engine import ple_pkg::*; #(
    parameter int DEPTH = PLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ple_req_if.sink     i_req,
    ple_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = ((CW > 5) ? CW : 5) + 1;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan_idx, n_scan_idx;
    logic [4:0]  r_max;
    logic        r_out_valid, n_out_valid;
    t_status     r_status, n_status;
    logic [31:0] r_read, n_read;
    logic [4:0]  r_found, n_found;

    t_cell_cmd   w_cmd;
    t_req_type   w_req;
    logic        w_take;
    logic        w_cfg_wr;
    logic [W-1:0] w_pos, w_cnt, w_lim;
    logic        w_ins_ok, w_del_ok, w_get_ok;
    logic        w_hit, w_last, w_done;
    logic [31:0] w_read;

    logic [31:0] w_value    [DEPTH];
    logic [31:0] w_sel      [DEPTH];
    logic        w_match    [DEPTH];
    logic [DEPTH-1:0] w_col [32];

    // Row of cells, each linked to both neighbours
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        ple_cell #(.IDX(k)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left        ((k == 0) ? 32'd0 : w_value[(k == 0) ? 0 : k - 1]),
            .i_right       ((k == DEPTH - 1) ? 32'd0 : w_value[(k == DEPTH - 1) ? k : k + 1]),
            .i_right_match ((k == DEPTH - 1) ? 1'b0 : w_match[(k == DEPTH - 1) ? k : k + 1]),
            .o_value       (w_value[k]),
            .o_match       (w_match[k]),
            .o_sel_value   (w_sel[k])
        );
        for (genvar b = 0; b < 32; b++) begin : g_bit
            assign w_col[b][k] = w_sel[k][b];
        end
    end

    // Combine the one selected slot onto the read bus
    for (genvar b = 0; b < 32; b++) begin : g_read
        assign w_read[b] = |w_col[b];
    end

    // Decode the request against count and limit
    assign w_req  = t_req_type'(i_req.req_type);
    assign w_take = i_req.valid && i_req.ready;
    assign w_pos  = W'(i_req.position);
    assign w_cnt  = W'(r_count);
    assign w_lim  = (W'(r_max) < W'(DEPTH)) ? W'(r_max) : W'(DEPTH);

    assign w_ins_ok = (w_pos != '0) && (w_pos <= w_cnt + W'(1)) && (w_cnt < w_lim);
    assign w_del_ok = (w_pos != '0) && (w_pos <= w_cnt);
    assign w_get_ok = (w_pos != '0) && (w_pos <= w_lim);

    // Scan end: a hit at the head or the last entry in use reached
    assign w_hit  = w_match[0] && (r_count != '0);
    assign w_last = ((CW + 1)'(r_scan_idx) + (CW + 1)'(1)) >= (CW + 1)'(r_count);
    assign w_done = w_hit || w_last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN:  if (w_take && (w_req == REQ_LOCATE)) n_state = ST_SCAN;
            ST_SCAN: if (w_done) n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    // Outputs of the sequencer: handshake and cell command
    always_comb begin
        i_req.ready = 1'b0;
        w_cmd.op    = CELL_HOLD;
        w_cmd.pos   = i_req.position;
        w_cmd.value = i_req.value;
        case (r_state)
            ST_RUN: begin
                i_req.ready = !r_out_valid || o_rsp.ready;
                if (w_take) begin
                    case (w_req)
                        REQ_INSERT: if (w_ins_ok) w_cmd.op = CELL_INSERT;
                        REQ_DELETE: if (w_del_ok) w_cmd.op = CELL_DELETE;
                        REQ_LOCATE: w_cmd.op = CELL_MATCH;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: if (!w_done) w_cmd.op = CELL_SCAN;
            default: ;
        endcase
    end

    // Result, count and scan index
    always_comb begin
        n_count     = r_count;
        n_scan_idx  = r_scan_idx;
        n_status    = r_status;
        n_read      = r_read;
        n_found     = r_found;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (r_state == ST_RUN && w_take) begin
            n_read     = 32'd0;
            n_found    = 5'd0;
            n_status   = STS_OK;
            n_scan_idx = '0;
            case (w_req)
                REQ_INSERT: begin
                    n_out_valid = 1'b1;
                    if ((w_pos == '0) || (w_pos > w_cnt + W'(1))) begin
                        n_status = STS_BADPOS;
                    end else if (!w_ins_ok) begin
                        n_status = STS_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_DELETE: begin
                    n_out_valid = 1'b1;
                    if (w_del_ok) begin
                        n_read  = w_read;
                        n_count = r_count - CW'(1);
                    end else begin
                        n_status = STS_BADPOS;
                    end
                end
                REQ_GET: begin
                    n_out_valid = 1'b1;
                    if (w_get_ok) begin
                        n_read = w_read;
                    end else begin
                        n_status = STS_BADPOS;
                    end
                end
                default: ;
            endcase
        end else if (r_state == ST_SCAN) begin
            if (w_hit) begin
                n_out_valid = 1'b1;
                n_status    = STS_OK;
                n_found     = 5'((CW + 1)'(r_scan_idx) + (CW + 1)'(1));
            end else if (w_last) begin
                n_out_valid = 1'b1;
                n_status    = STS_NOTFOUND;
            end else begin
                n_scan_idx = r_scan_idx + CW'(1);
            end
        end
    end

    // Hold control state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= STS_OK;
            r_read   <= '0;
            r_found  <= '0;
        end else begin
            r_status <= n_status;
            r_read   <= n_read;
            r_found  <= n_found;
        end
    end

    // Register port
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (32'(paddr[2]) == REG_MAX_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= PLE_MAX_RESET;
        end else if (w_cfg_wr) begin
            r_max <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (32'(paddr[2]) == REG_MAX_ENTRIES) ? {27'd0, r_max} : 32'd0;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.read_value     = r_read;
    assign o_rsp.found_position = r_found;

endmodule

[rtl/core/ple_checker.sv]
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
module ple_checker import ple_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_read_value,
    input logic [4:0]  i_found_position
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // Drop the response register at reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Refuse requests while a response is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !i_req_ready)
        else $error("request taken over a stalled response");

    // A found position only comes with success and no read data
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_found_position != 5'd0))
            |-> ((i_status == STS_OK) && (i_read_value == 32'd0)))
        else $error("found position on a failed or reading request");

    // Read data only comes with success
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_read_value != 32'd0)) |-> (i_status == STS_OK))
        else $error("read data on a refused request");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_read_value     (o_rsp.read_value),
    .i_found_position (o_rsp.found_position)
);

[bench/positional_list_engine_tb.sv]
// Self-checking bench for the positional list engine: directed edge cases,
// limit settings over APB and long random traffic with stalls on both sides.
// Depends on ple_pkg, ple_if and positional_list_engine.
module positional_list_engine_tb;
    import ple_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic [4:0]  found_position;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // Request side drive
    logic        req_valid = 1'b0;
    t_req_type   req_op = REQ_GET;
    logic [4:0]  req_pos = '0;
    logic [31:0] req_val = '0;

    // Response side drive
    logic        rsp_ready = 1'b0;
    int          stall_left = 0;

    // APB drive
    logic        apb_sel = 1'b0;
    logic        apb_enable = 1'b0;
    logic        apb_write = 1'b0;
    logic [2:0]  apb_addr = '0;
    logic [31:0] apb_wdata = '0;
    logic [31:0] apb_rdata;
    logic        apb_ready;

    // Shadow of the list as the block should hold it
    logic [31:0] list_slot [PLE_DEPTH];
    int unsigned list_len = 0;
    logic [4:0]  max_entries_shadow = PLE_MAX_RESET;

    list_result_t expected_results[$];
    list_result_t got_result;
    list_result_t want_result;
    int           mismatch_count = 0;
    bit           gaps_on = 1'b1;

    ple_req_if req_if();
    ple_rsp_if rsp_if();

    assign req_if.valid    = req_valid;
    assign req_if.req_type = req_op;
    assign req_if.position = req_pos;
    assign req_if.value    = req_val;
    assign rsp_if.ready    = rsp_ready;

    positional_list_engine u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (apb_sel),
        .penable (apb_enable),
        .pwrite  (apb_write),
        .paddr   (apb_addr),
        .pwdata  (apb_wdata),
        .prdata  (apb_rdata),
        .pready  (apb_ready)
    );

    always #2 clk = ~clk;

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    function automatic int effective_limit();
        return (max_entries_shadow < PLE_DEPTH) ? int'(max_entries_shadow) : PLE_DEPTH;
    endfunction

    // Extremes, a small pool that repeats, or anything
    function automatic logic [31:0] pick_entry_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end else if (r < 40) begin
            return 32'($urandom_range(0, 7));
        end
        return $urandom;
    endfunction

    // Apply one request to the shadow list and work out its response
    task automatic apply_list_request(input t_req_type op, input logic [4:0] pos,
                                      input logic [31:0] val, output list_result_t res);
        int lim;
        int p;
        lim = effective_limit();
        p = int'(pos);
        res.status = STS_OK;
        res.read_value = '0;
        res.found_position = '0;
        case (op)
            REQ_INSERT: begin
                if (p < 1 || p > int'(list_len) + 1) begin
                    res.status = STS_BADPOS;
                end else if (int'(list_len) >= lim) begin
                    res.status = STS_FULL;
                end else begin
                    for (int j = int'(list_len); j >= p; j--) begin
                        list_slot[j] = list_slot[j-1];
                    end
                    list_slot[p-1] = val;
                    list_len++;
                end
            end
            REQ_DELETE: begin
                if (p < 1 || p > int'(list_len)) begin
                    res.status = STS_BADPOS;
                end else begin
                    res.read_value = list_slot[p-1];
                    for (int j = p; j < int'(list_len); j++) begin
                        list_slot[j-1] = list_slot[j];
                    end
                    list_slot[list_len-1] = '0;
                    list_len--;
                end
            end
            REQ_GET: begin
                if (p < 1 || p > lim) begin
                    res.status = STS_BADPOS;
                end else begin
                    res.read_value = list_slot[p-1];
                end
            end
            default: begin
                res.status = STS_NOTFOUND;
                for (int j = 0; j < int'(list_len); j++) begin
                    if (list_slot[j] == val) begin
                        res.status = STS_OK;
                        res.found_position = 5'(j + 1);
                        break;
                    end
                end
            end
        endcase
    endtask

    // Offer one request and hold it until the transfer
    task automatic send_request(input t_req_type op, input logic [4:0] pos,
                                input logic [31:0] val);
        int gap;
        list_result_t res;
        gap = pick_gap();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op <= op;
        req_pos <= pos;
        req_val <= val;
        do @(posedge clk); while (!req_if.ready);
        apply_list_request(op, pos, val, res);
        expected_results.push_back(res);
    endtask

    // Drop the request and hold until every response has come back
    task automatic wait_results_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Write max_entries, then read it straight back
    task automatic program_max_entries(input logic [4:0] limit_value);
        wait_results_drained();
        apb_sel <= 1'b1;
        apb_enable <= 1'b0;
        apb_write <= 1'b1;
        apb_addr <= 3'(REG_MAX_ENTRIES * 4);
        apb_wdata <= {27'd0, limit_value};
        @(posedge clk);
        apb_enable <= 1'b1;
        do @(posedge clk); while (!apb_ready);
        max_entries_shadow = limit_value;
        // back-to-back read
        apb_enable <= 1'b0;
        apb_write <= 1'b0;
        @(posedge clk);
        apb_enable <= 1'b1;
        do @(posedge clk); while (!apb_ready);
        if (apb_rdata !== {27'd0, limit_value}) begin
            if (mismatch_count < 10) begin
                $display("max_entries readback: expected %0d got %0h", limit_value, apb_rdata);
            end
            mismatch_count++;
        end
        apb_sel <= 1'b0;
        apb_enable <= 1'b0;
    endtask

    // Mostly well-formed requests against the current list, some noise
    task automatic send_random_request();
        int r;
        int lim;
        t_req_type op;
        logic [4:0] pos;
        logic [31:0] val;
        lim = effective_limit();
        val = pick_entry_value();
        r = $urandom_range(0, 99);
        if (r < 10) begin
            op = t_req_type'($urandom_range(0, 3));
            pos = 5'($urandom_range(0, 31));
            val = $urandom;
        end else begin
            r = $urandom_range(0, 99);
            if (r < ((int'(list_len) >= lim) ? 20 : 45)) begin
                op = REQ_INSERT;
            end else if (r < 70) begin
                op = REQ_DELETE;
            end else if (r < 85) begin
                op = REQ_GET;
            end else begin
                op = REQ_LOCATE;
            end
            case (op)
                REQ_INSERT: pos = 5'($urandom_range(1, list_len + 1));
                REQ_DELETE: pos = (list_len == 0) ? 5'd1 : 5'($urandom_range(1, list_len));
                REQ_GET:    pos = (lim == 0) ? 5'd1 : 5'($urandom_range(1, lim));
                default: begin
                    pos = 5'($urandom_range(0, 31));
                    if (list_len != 0 && $urandom_range(0, 9) < 7) begin
                        val = list_slot[$urandom_range(0, list_len - 1)];
                    end
                end
            endcase
        end
        send_request(op, pos, val);
    endtask

    // Receiver stalls at random
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rsp_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Compare each response transfer with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got_result.status = t_status'(rsp_if.status);
            got_result.read_value = rsp_if.read_value;
            got_result.found_position = rsp_if.found_position;
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("response with nothing outstanding: status %0d read %0h found %0d",
                             got_result.status, got_result.read_value,
                             got_result.found_position);
                end
                mismatch_count++;
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.status !== want_result.status ||
                    got_result.read_value !== want_result.read_value ||
                    got_result.found_position !== want_result.found_position) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: status %0d/%0d read %0h/%0h found %0d/%0d",
                                 want_result.status, got_result.status,
                                 want_result.read_value, got_result.read_value,
                                 want_result.found_position, got_result.found_position);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Field extremes, refusals and the first locate hit on a short list
    task automatic test_directed_edges();
        gaps_on = 1'b1;
        send_request(REQ_GET, 5'd0, '0);
        send_request(REQ_GET, 5'd1, '0);
        send_request(REQ_GET, 5'd16, '0);
        send_request(REQ_GET, 5'd17, '0);
        send_request(REQ_GET, 5'd31, '0);
        send_request(REQ_DELETE, 5'd1, '0);
        send_request(REQ_LOCATE, 5'd0, '0);
        send_request(REQ_INSERT, 5'd0, 32'h1234_5678);
        send_request(REQ_INSERT, 5'd2, 32'h1234_5678);
        send_request(REQ_INSERT, 5'd1, 32'h8000_0000);
        send_request(REQ_INSERT, 5'd2, 32'h7fff_ffff);
        send_request(REQ_INSERT, 5'd1, 32'hffff_ffff);
        send_request(REQ_INSERT, 5'd31, 32'h0000_0001);
        send_request(REQ_LOCATE, 5'd31, 32'hffff_ffff);
        send_request(REQ_LOCATE, 5'd0, 32'h7fff_ffff);
        send_request(REQ_LOCATE, 5'd0, 32'h0000_3039);
        send_request(REQ_DELETE, 5'd0, '0);
        send_request(REQ_DELETE, 5'd4, '0);
        send_request(REQ_DELETE, 5'd31, '0);
        send_request(REQ_DELETE, 5'd2, '0);
        send_request(REQ_GET, 5'd3, '0);
        send_request(REQ_GET, 5'd2, '0);
        wait_results_drained();
    endtask

    // Fill to the top, refuse, then free the last slot and the first
    task automatic test_full_list();
        gaps_on = 1'b0;
        send_request(REQ_INSERT, 5'(list_len + 1), 32'h5a5a_5a5a);
        send_request(REQ_INSERT, 5'd1, 32'h5a5a_5a5a);
        while (list_len < PLE_DEPTH) begin
            send_request(REQ_INSERT, 5'($urandom_range(1, list_len + 1)), pick_entry_value());
        end
        send_request(REQ_LOCATE, 5'd0, 32'h5a5a_5a5a);
        send_request(REQ_INSERT, 5'd1, 32'h0bad_0bad);
        send_request(REQ_INSERT, 5'd17, 32'h0bad_0bad);
        send_request(REQ_INSERT, 5'd18, 32'h0bad_0bad);
        send_request(REQ_GET, 5'd16, '0);
        send_request(REQ_LOCATE, 5'd0, list_slot[PLE_DEPTH-1]);
        send_request(REQ_DELETE, 5'd16, '0);
        send_request(REQ_GET, 5'd16, '0);
        send_request(REQ_DELETE, 5'd1, '0);
        wait_results_drained();
    endtask

    // Zero limit, limit above depth, limit lowered under the count
    task automatic test_limit_settings();
        gaps_on = 1'b1;
        while (list_len != 0) begin
            send_request(REQ_DELETE, 5'($urandom_range(1, list_len)), '0);
        end
        program_max_entries(5'd0);
        send_request(REQ_INSERT, 5'd1, 32'h0000_00aa);
        send_request(REQ_INSERT, 5'd2, 32'h0000_00aa);
        send_request(REQ_GET, 5'd1, '0);
        send_request(REQ_GET, 5'd0, '0);
        send_request(REQ_LOCATE, 5'd0, '0);
        program_max_entries(5'd31);
        send_request(REQ_GET, 5'd16, '0);
        send_request(REQ_GET, 5'd17, '0);
        repeat (6) begin
            send_request(REQ_INSERT, 5'(list_len + 1), pick_entry_value());
        end
        program_max_entries(5'd3);
        send_request(REQ_INSERT, 5'd1, 32'h0000_00bb);
        send_request(REQ_GET, 5'd3, '0);
        send_request(REQ_GET, 5'd4, '0);
        send_request(REQ_LOCATE, 5'd0, list_slot[5]);
        send_request(REQ_DELETE, 5'd6, '0);
        send_request(REQ_DELETE, 5'd4, '0);
        send_request(REQ_INSERT, 5'd1, 32'h0000_00cc);
        program_max_entries(5'd1);
        send_request(REQ_INSERT, 5'd1, 32'h0000_00dd);
        send_request(REQ_GET, 5'd1, '0);
        send_request(REQ_GET, 5'd2, '0);
        wait_results_drained();
    endtask

    // Phases of random traffic, each under its own limit
    task automatic test_random_traffic();
        logic [4:0] phase_limit [5];
        phase_limit[0] = 5'd16;
        phase_limit[1] = 5'($urandom_range(1, 15));
        phase_limit[2] = 5'd31;
        phase_limit[3] = 5'd2;
        phase_limit[4] = 5'($urandom_range(0, 31));
        for (int ph = 0; ph < 5; ph++) begin
            program_max_entries(phase_limit[ph]);
            for (int n = 0; n < 400; n++) begin
                if (n % 50 == 0) begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                end
                send_random_request();
            end
        end
        wait_results_drained();
    endtask

    initial begin
        for (int k = 0; k < PLE_DEPTH; k++) begin
            list_slot[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_full_list();
        test_limit_settings();
        test_random_traffic();
        wait_results_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[positional_list_engine] OK");
        end else begin
            $display("[positional_list_engine] ERROR");
        end
        $finish;
    end

    // Guard against a hang
    initial begin
        #4000000;
        $display("[positional_list_engine] ERROR");
        $finish;
    end

endmodule
